/* hw/rtl/rls_pkg.sv */
// ----------------------------------------------------------------------------
// rls_pkg
// Shared types and constants for the region latency statistics block.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int unsigned ActW          = 2;
  localparam int unsigned RegionW       = 8;
  localparam int unsigned TimeW         = 64;
  localparam int unsigned CountW        = 32;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned CfgW          = 9;
  localparam int unsigned MaxRegionsDef = 256;

  typedef enum logic [ActW-1:0] {
    ACT_BEGIN = 2'd0,
    ACT_END   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_e;

  typedef enum logic [StatusW-1:0] {
    STS_DONE    = 2'd0,
    STS_RANGE   = 2'd1,
    STS_NOBEGIN = 2'd2
  } status_e;

  // One statistics entry as stored in memory
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  total;
    logic [TimeW-1:0]  min;
    logic [TimeW-1:0]  max;
  } stats_t;

  // Entry value after a clear
  localparam stats_t StatsInit = '{
    count: '0,
    total: '0,
    min:   '1,
    max:   '0
  };

endpackage

/* hw/rtl/rls_ram.sv */
// ----------------------------------------------------------------------------
// rls_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module rls_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rls_update.sv */
// ----------------------------------------------------------------------------
// rls_update
// Statistics update: folds one interval into an entry and selects the
// statistics returned with the result.
// ----------------------------------------------------------------------------
module rls_update (
  input  rls_pkg::act_e                act_i,
  input  rls_pkg::status_e             status_i,
  input  logic [rls_pkg::TimeW-1:0]    dt_i,
  input  rls_pkg::stats_t              entry_i,
  output rls_pkg::stats_t              entry_o,
  output logic                         we_o,
  output rls_pkg::stats_t              result_o
);

  rls_pkg::stats_t upd;
  logic            done;

  // Fold the interval in: saturating count, wrapping total, min and max
  always_comb begin
    upd.count = (&entry_i.count) ? entry_i.count : entry_i.count + rls_pkg::CountW'(1);
    upd.total = entry_i.total + dt_i;
    upd.min   = (dt_i < entry_i.min) ? dt_i : entry_i.min;
    upd.max   = (dt_i > entry_i.max) ? dt_i : entry_i.max;
  end

  assign done = (status_i == rls_pkg::STS_DONE);

  // Write back on a good end; report stats on a good end or read
  always_comb begin
    entry_o  = upd;
    we_o     = 1'b0;
    result_o = '0;
    unique case (act_i)
      rls_pkg::ACT_END: begin
        if (done) begin
          we_o     = 1'b1;
          result_o = upd;
        end
      end
      rls_pkg::ACT_READ: begin
        if (done) begin
          result_o = entry_i;
        end
      end
      rls_pkg::ACT_BEGIN, rls_pkg::ACT_CLEAR: begin
        result_o = '0;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/region_latency_statistics.sv */
// ----------------------------------------------------------------------------
// region_latency_statistics
// Per-region latency monitor: begin/end markers accumulate count, total,
// minimum and maximum interval per region in one statistics RAM.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | action_i, region_i, timestamp_i
//  out     | output    | out_valid_o/ out_stall_i| status_o, call_count_o,
//          |           |                         | total_time_o, min_time_o,
//          |           |                         | max_time_o
//  cfg     | input     | cfg_valid_i/ cfg_ready_o| regions_in_use_i
//
//  Items are handled one at a time: the region's entry is read from the RAM,
//  then updated, written back and loaded into the output register.
//  After reset, a clear action and each config write, a clearing pass writes
//  every RAM entry once, while no item is accepted.
//  The output register holds a result while out_stall_i is high; the next
//  item is accepted meanwhile and waits in its update cycle.
//
module region_latency_statistics #(
  parameter int unsigned MAX_REGIONS = rls_pkg::MaxRegionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rls_pkg::ActW-1:0]      action_i,
  input  logic [rls_pkg::RegionW-1:0]   region_i,
  input  logic [rls_pkg::TimeW-1:0]     timestamp_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rls_pkg::StatusW-1:0]   status_o,
  output logic [rls_pkg::CountW-1:0]    call_count_o,
  output logic [rls_pkg::TimeW-1:0]     total_time_o,
  output logic [rls_pkg::TimeW-1:0]     min_time_o,
  output logic [rls_pkg::TimeW-1:0]     max_time_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rls_pkg::CfgW-1:0]      regions_in_use_i
);

  localparam int unsigned AddrW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned StatsW = $bits(rls_pkg::stats_t);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [AddrW-1:0]             clr_addr_q, clr_addr_d;
  logic [rls_pkg::CfgW-1:0]     regions_q;
  logic [rls_pkg::TimeW-1:0]    start_q;
  logic [rls_pkg::RegionW-1:0]  open_q;
  rls_pkg::act_e                act_q;
  rls_pkg::status_e             status_q;
  logic [rls_pkg::TimeW-1:0]    dt_q;
  logic [AddrW-1:0]             addr_q;
  logic                         out_valid_q;
  rls_pkg::status_e             out_status_q;
  rls_pkg::stats_t              out_stats_q;

  logic                         in_xfer;
  logic                         cfg_xfer;
  logic                         lookup_adv;
  logic                         in_range;
  rls_pkg::act_e                act_in;
  rls_pkg::status_e             status_in;
  logic                         ram_we;
  logic [AddrW-1:0]             ram_waddr;
  logic [StatsW-1:0]            ram_wdata;
  logic [StatsW-1:0]            ram_rdata;
  rls_pkg::stats_t              upd_entry;
  logic                         upd_we;
  rls_pkg::stats_t              upd_result;

  // Handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign lookup_adv  = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);

  // Classify the incoming item
  assign act_in   = rls_pkg::act_e'(action_i);
  assign in_range = (32'(region_i) < 32'(regions_q)) && (32'(region_i) < MAX_REGIONS);

  always_comb begin
    priority if (act_in == rls_pkg::ACT_CLEAR) begin
      status_in = rls_pkg::STS_DONE;
    end else if (!in_range) begin
      status_in = rls_pkg::STS_RANGE;
    end else if (act_in == rls_pkg::ACT_END && region_i != open_q) begin
      status_in = rls_pkg::STS_NOBEGIN;
    end else begin
      status_in = rls_pkg::STS_DONE;
    end
  end

  // Control sequence: clearing pass, wait for item, update
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_addr_q == AddrW'(MAX_REGIONS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (lookup_adv) begin
          clr_addr_d = '0;
          state_d    = (act_q == rls_pkg::ACT_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // A register write restarts the clearing pass
    if (cfg_xfer) begin
      state_d    = ST_CLEAR;
      clr_addr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      regions_q  <= '0;
      start_q    <= '0;
      open_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      if (cfg_xfer) begin
        regions_q <= regions_in_use_i;
      end
      // Record the begin marker
      if (in_xfer && act_in == rls_pkg::ACT_BEGIN && in_range) begin
        start_q <= timestamp_i;
        open_q  <= region_i;
      end
    end
  end

  // Hold the accepted item for its update cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q    <= act_in;
      status_q <= status_in;
      dt_q     <= timestamp_i - start_q;
      addr_q   <= AddrW'(region_i);
    end
  end

  // Statistics memory
  assign ram_we    = (state_q == ST_CLEAR) || (lookup_adv && upd_we);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? StatsW'(rls_pkg::StatsInit) : StatsW'(upd_entry);

  rls_ram #(
    .Width (StatsW),
    .Depth (MAX_REGIONS)
  ) u_stats_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer),
    .raddr_i (AddrW'(region_i)),
    .rdata_o (ram_rdata)
  );

  rls_update u_update (
    .act_i    (act_q),
    .status_i (status_q),
    .dt_i     (dt_q),
    .entry_i  (rls_pkg::stats_t'(ram_rdata)),
    .entry_o  (upd_entry),
    .we_o     (upd_we),
    .result_o (upd_result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lookup_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lookup_adv) begin
      out_status_q <= status_q;
      out_stats_q  <= upd_result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign call_count_o = out_stats_q.count;
  assign total_time_o = out_stats_q.total;
  assign min_time_o   = out_stats_q.min;
  assign max_time_o   = out_stats_q.max;

endmodule
